// ===== design/sdf_pkg.sv =====
// Shared types and constants of the sensor reply deframer.
`timescale 1ns / 1ps

package sdf_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    // Byte positions within a frame, counted from zero
    localparam int unsigned POS_SECOND  = 1;
    localparam int unsigned POS_TYPE    = 6;
    localparam int unsigned POS_LEN_HI  = 7;
    localparam int unsigned POS_LEN_LO  = 8;
    localparam int unsigned POS_PAYLOAD = 9;

    // Smallest legal length field (checksum bytes only)
    localparam logic [15:0] MIN_LENGTH = 16'd2;

    // Register map
    localparam int unsigned APB_ADDR_W       = 3;
    localparam logic [2:0]  ADDR_START_CODE  = 3'd0;
    localparam logic [15:0] START_CODE_RESET = 16'hEF01;

    // Queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // One classified result on its way to the back end
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] plen;
    } item_t;

endpackage

// ===== design/sdf_front.sv =====
// Front end: accepts received bytes, tracks frame position and classifies results.
`timescale 1ns / 1ps

module sdf_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     rx_byte,
    input  logic [15:0]    start_code,
    input  logic           q_full,
    output logic           q_push,
    output sdf_pkg::item_t q_item
);

    // Counter holds positions up to one past the last checksum byte
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 11);
    localparam logic [16:0] MAX_LENGTH = 17'(MAX_PAYLOAD + 2);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] end_pos_reg, end_pos_next;
    logic [7:0]       second_reg, second_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [15:0]      plen_reg, plen_next;

    logic        accept;
    logic [15:0] length;
    logic        frame_bad;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    // Check the header once the length low byte is here
    assign length    = {len_hi_reg, rx_byte};
    assign frame_bad = (second_reg != start_code[7:0]) || (length < sdf_pkg::MIN_LENGTH)
                       || ({1'b0, length} > MAX_LENGTH);

    // Advance the frame position and classify the byte
    always_comb
    begin
        pos_next     = pos_reg;
        end_pos_next = end_pos_reg;
        second_next  = second_reg;
        type_next    = type_reg;
        len_hi_next  = len_hi_reg;
        plen_next    = plen_reg;
        q_push       = 1'b0;
        q_item       = '0;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                if (rx_byte == start_code[15:8])
                begin
                    pos_next = CNT_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + CNT_W'(1);
                if (pos_reg == CNT_W'(sdf_pkg::POS_SECOND))
                begin
                    second_next = rx_byte;
                end
                else if (pos_reg == CNT_W'(sdf_pkg::POS_TYPE))
                begin
                    type_next = rx_byte;
                end
                else if (pos_reg == CNT_W'(sdf_pkg::POS_LEN_HI))
                begin
                    len_hi_next = rx_byte;
                end
                else if (pos_reg == CNT_W'(sdf_pkg::POS_LEN_LO))
                begin
                    q_push = 1'b1;
                    if (frame_bad)
                    begin
                        pos_next    = '0;
                        q_item.kind = sdf_pkg::KIND_BAD;
                    end
                    else
                    begin
                        plen_next    = length - sdf_pkg::MIN_LENGTH;
                        end_pos_next = CNT_W'(sdf_pkg::POS_PAYLOAD)
                                       + CNT_W'(length - sdf_pkg::MIN_LENGTH);
                        q_item.kind  = sdf_pkg::KIND_TYPE;
                        q_item.data  = type_reg;
                    end
                end
                else if (pos_reg >= CNT_W'(sdf_pkg::POS_PAYLOAD))
                begin
                    if (pos_reg < end_pos_reg)
                    begin
                        q_push      = 1'b1;
                        q_item.kind = sdf_pkg::KIND_PAYLOAD;
                        q_item.data = rx_byte;
                    end
                    else if (pos_reg != end_pos_reg)
                    begin
                        // second checksum byte closes the frame
                        pos_next    = '0;
                        q_push      = 1'b1;
                        q_item.kind = sdf_pkg::KIND_END;
                        q_item.plen = plen_reg;
                    end
                end
            end
        end
    end

    // Hold frame position and captured header fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            end_pos_reg <= '0;
            second_reg  <= '0;
            type_reg    <= '0;
            len_hi_reg  <= '0;
            plen_reg    <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            end_pos_reg <= end_pos_next;
            second_reg  <= second_next;
            type_reg    <= type_next;
            len_hi_reg  <= len_hi_next;
            plen_reg    <= plen_next;
        end
    end

endmodule

// ===== design/sdf_queue.sv =====
// Short queue of classified results between the front and back ends.
`timescale 1ns / 1ps

module sdf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sdf_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sdf_pkg::item_t head_item
);

    sdf_pkg::item_t mem [sdf_pkg::QDEPTH];

    logic [sdf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sdf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sdf_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == sdf_pkg::QCNT_W'(sdf_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + sdf_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + sdf_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + sdf_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - sdf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/sdf_back.sv =====
// Back end: drains the queue into the output register and forms result transactions.
`timescale 1ns / 1ps

module sdf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  sdf_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     kind,
    output logic [7:0]     data,
    output logic [15:0]    payload_length,
    output logic           last
);

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] plen_reg;
    logic        last_reg;
    logic        load;

    // Load when the output register is empty or its transaction completes
    assign load  = q_not_empty && (!valid_reg || !out_stall);
    assign q_pop = load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture each result; frame end and bad frame close the frame
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= q_item.kind;
            data_reg <= q_item.data;
            plen_reg <= q_item.plen;
            last_reg <= (q_item.kind == sdf_pkg::KIND_END)
                        || (q_item.kind == sdf_pkg::KIND_BAD);
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign data           = data_reg;
    assign payload_length = plen_reg;
    assign last           = last_reg;

endmodule

// ===== design/sensor_reply_deframer.sv =====
// Path: each accepted byte's result enters the queue and is then registered at the output.
// Throughput: one byte per cycle unless the input stalls; the front end's byte position
// counter classifies each byte on acceptance and a two-entry queue feeds the output register.
// Output stalls fill the queue, and the input stalls while both entries are held.
// Reset: rst_n (asynchronous, active low) restores start_code to 0xEF01, clears the
// frame position to hunting and empties the queue and output register.
`timescale 1ns / 1ps

module sensor_reply_deframer #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sdf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Received bytes
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    // Results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [7:0]                     data,
    output logic [15:0]                    payload_length,
    output logic                           last
);

    logic [15:0]    start_code_reg, start_code_next;
    logic           q_push, q_full, q_pop, q_not_empty;
    sdf_pkg::item_t push_item, head_item;

    // Configuration register
    assign pready = 1'b1;

    always_comb
    begin
        start_code_next = start_code_reg;
        if (psel && penable && pwrite && (paddr == sdf_pkg::ADDR_START_CODE))
        begin
            start_code_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= sdf_pkg::START_CODE_RESET;
        end
        else
        begin
            start_code_reg <= start_code_next;
        end
    end

    assign prdata = (paddr == sdf_pkg::ADDR_START_CODE) ? {16'd0, start_code_reg} : 32'd0;

    sdf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .start_code (start_code_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    sdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    sdf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_item         (head_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .data           (data),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

// ===== verif/sensor_reply_deframer_tb.sv =====
// Self-checking testbench for the sensor reply deframer: framed byte streams in, results checked.
`timescale 1ns / 1ps

module sensor_reply_deframer_tb;

    localparam int MAX_PAYLOAD   = 256;
    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 6;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 1400;
    localparam int MAX_IDLE      = 15;
    localparam int MAX_PRINTS    = 50;
    localparam int RANDOM_FILL   = -1;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    // One expected deframer result
    typedef struct packed {
        sdf_pkg::kind_t kind;
        logic [7:0]     data;
        logic [15:0]    plen;
        logic           last;
    } frame_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] payload_length;
    logic        last;

    // Deframer shadow state
    logic [15:0] model_code = sdf_pkg::START_CODE_RESET;
    logic [16:0] frame_pos = '0;
    logic [7:0]  held_second = '0;
    logic [7:0]  held_type = '0;
    logic [15:0] held_length = '0;

    frame_event_t expected_events[$];
    int mismatch_count = 0;
    int framed_count = 0;
    int max_gap = 0;
    int max_stall = 0;
    int cycle_count = 0;

    sensor_reply_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .data(data),
        .payload_length(payload_length),
        .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the shadow deframer by one byte and queue what it emits
    function automatic void deframe_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned payload;
        pos = frame_pos;
        if (pos == 0)
        begin
            if (b == model_code[15:8])
                frame_pos = 17'd1;
        end
        else
        begin
            frame_pos = 17'(pos + 1);
            if (pos == sdf_pkg::POS_SECOND)
                held_second = b;
            else if (pos == sdf_pkg::POS_TYPE)
                held_type = b;
            else if (pos == sdf_pkg::POS_LEN_HI)
                held_length = {b, 8'h00};
            else if (pos == sdf_pkg::POS_LEN_LO)
            begin
                held_length[7:0] = b;
                if (held_second != model_code[7:0] || held_length < sdf_pkg::MIN_LENGTH ||
                    int'(held_length) - 2 > MAX_PAYLOAD)
                begin
                    frame_pos = '0;
                    expected_events.push_back('{sdf_pkg::KIND_BAD, 8'h00, 16'h0000, 1'b1});
                end
                else
                    expected_events.push_back('{sdf_pkg::KIND_TYPE, held_type, 16'h0000,
                                                1'b0});
            end
            else if (pos >= sdf_pkg::POS_PAYLOAD)
            begin
                payload = held_length - 16'd2;
                if (pos < sdf_pkg::POS_PAYLOAD + payload)
                    expected_events.push_back('{sdf_pkg::KIND_PAYLOAD, b, 16'h0000, 1'b0});
                else if (pos > sdf_pkg::POS_PAYLOAD + payload)
                begin
                    // second checksum byte closes the frame
                    frame_pos = '0;
                    expected_events.push_back('{sdf_pkg::KIND_END, 8'h00, 16'(payload),
                                                1'b1});
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one byte after a random gap, hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        logic [16:0] pos_before;
        gap = $urandom_range(max_gap, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pos_before = frame_pos;
        deframe_byte(b);
        if (pos_before != 0 || frame_pos != 0)
            framed_count++;
    endtask

    // Send a frame header, then fill until the deframer closes the open frame
    task automatic send_frame(input logic [15:0] code, input logic [7:0] ptype,
                              input logic [15:0] len_field, input int fill);
        send_byte(code[15:8]);
        send_byte(code[7:0]);
        repeat (4) send_byte(8'($urandom));
        send_byte(ptype);
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        while (frame_pos != 0)
            send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    // Drop valid and hold until every expected result is out and the pipe is empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access phase of one register write
    task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == sdf_pkg::ADDR_START_CODE)
            model_code = value;
    endtask

    task automatic set_idling(input int gap, input int stall);
        max_gap   = gap;
        max_stall = stall;
    endtask

    task automatic test_hunting_and_good_frames();
        set_idling(0, 0);
        // noise while hunting, including the start low byte alone
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        // empty payload, then single bytes at the extremes
        send_frame(model_code, 8'h00, 16'd2, RANDOM_FILL);
        send_frame(model_code, 8'hFF, 16'd3, 8'h00);
        send_frame(model_code, 8'hA5, 16'd3, 8'hFF);
    endtask

    task automatic test_bad_frames();
        set_idling(MAX_IDLE, MAX_IDLE);
        send_frame({model_code[15:8], ~model_code[7:0]}, 8'h11, 16'd4, RANDOM_FILL);
        send_frame(model_code, 8'h22, 16'd0, RANDOM_FILL);
        send_frame(model_code, 8'h33, 16'd1, RANDOM_FILL);
        send_frame(model_code, 8'h44, 16'(MAX_PAYLOAD + 3), RANDOM_FILL);
        send_frame(model_code, 8'h55, 16'hFFFF, RANDOM_FILL);
    endtask

    task automatic test_start_code_writes();
        logic [15:0] codes[4];
        logic [15:0] old_code;
        codes = '{16'h0000, 16'hFFFF, 16'($urandom), sdf_pkg::START_CODE_RESET};
        set_idling(0, MAX_IDLE);
        foreach (codes[i])
        begin
            old_code = model_code;
            wait_drained();
            apb_write(sdf_pkg::ADDR_START_CODE, codes[i]);
            send_frame(model_code, 8'($urandom), 16'($urandom_range(6, 2)), RANDOM_FILL);
            send_frame(old_code, 8'($urandom), 16'd3, RANDOM_FILL);
        end
        // unmapped address leaves the start code alone
        wait_drained();
        apb_write(ADDR_UNMAPPED, 16'h1234);
        send_frame(model_code, 8'h5A, 16'd3, RANDOM_FILL);
    endtask

    task automatic test_mid_frame_write();
        set_idling(MAX_IDLE, 0);
        // new low byte no longer matches the second byte already taken
        send_frame(sdf_pkg::START_CODE_RESET, 8'h01, 16'd0, RANDOM_FILL);
        wait_drained();
        send_byte(model_code[15:8]);
        send_byte(model_code[7:0]);
        repeat (4) send_byte(8'($urandom));
        wait_drained();
        apb_write(sdf_pkg::ADDR_START_CODE, {model_code[15:8], model_code[7:0] ^ 8'h5A});
        send_frame(16'h0000, 8'h77, 16'd3, RANDOM_FILL);
        // second byte taken under the old code matches the new one
        wait_drained();
        send_byte(model_code[15:8]);
        send_byte(8'h3C);
        send_byte(8'($urandom));
        wait_drained();
        apb_write(sdf_pkg::ADDR_START_CODE, {model_code[15:8], 8'h3C});
        repeat (3) send_byte(8'($urandom));
        send_byte(8'h88);
        send_byte(8'h00);
        send_byte(8'h04);
        while (frame_pos != 0)
            send_byte(8'($urandom));
        wait_drained();
        apb_write(sdf_pkg::ADDR_START_CODE, sdf_pkg::START_CODE_RESET);
    endtask

    task automatic test_random_traffic();
        int first;
        int pick;
        int size;
        logic [15:0] len_field;
        logic [15:0] code;
        first = framed_count;
        while (framed_count - first < RANDOM_BYTES)
        begin
            // switch idling pattern now and then
            if ($urandom_range(9) == 0)
            begin
                pick = $urandom_range(3);
                set_idling(pick[0] ? MAX_IDLE : 0, pick[1] ? MAX_IDLE : 0);
            end
            // hold off until all results are out, sometimes with a new start code
            if ($urandom_range(24) == 0)
                wait_drained();
            if ($urandom_range(29) == 0)
            begin
                wait_drained();
                pick = $urandom_range(3);
                code = pick == 0 ? sdf_pkg::START_CODE_RESET : pick == 1 ? 16'h0000 :
                       pick == 2 ? 16'hFFFF : 16'($urandom);
                apb_write(sdf_pkg::ADDR_START_CODE, code);
            end
            pick = $urandom_range(99);
            if (pick < 8)
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
            else if (pick < 20)
            begin
                code = model_code;
                len_field = 16'($urandom_range(8, 2));
                case ($urandom_range(3))
                    0: code[7:0] = code[7:0] ^ 8'($urandom_range(255, 1));
                    1: len_field = 16'($urandom_range(1, 0));
                    2: len_field = 16'(MAX_PAYLOAD + 3);
                    default: len_field = 16'($urandom_range(65535, MAX_PAYLOAD + 3));
                endcase
                send_frame(code, 8'($urandom), len_field, RANDOM_FILL);
            end
            else
            begin
                // mostly short payloads, a few near or at the maximum
                pick = $urandom_range(99);
                if (pick < 85)
                    size = $urandom_range(12, 0);
                else if (pick < 97)
                    size = $urandom_range(64, 13);
                else if (pick < 99)
                    size = $urandom_range(MAX_PAYLOAD, 200);
                else
                    size = MAX_PAYLOAD;
                send_frame(model_code, 8'($urandom), 16'(size + 2), RANDOM_FILL);
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        frame_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch("result with nothing expected, kind", 32'(kind), 32'd0);
            else
            begin
                want = expected_events.pop_front();
                if (kind != want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (data != want.data)
                    report_mismatch("data", 32'(data), 32'(want.data));
                if (payload_length != want.plen)
                    report_mismatch("payload_length", 32'(payload_length), 32'(want.plen));
                if (last != want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    // Stall the result side for a random count after each transaction
    always @(posedge clk)
    begin
        int stall_left;
        int draw;
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= (stall_left != 0);
        end
        else if (out_valid && !out_stall)
        begin
            draw = $urandom_range(max_stall, 0);
            stall_left = draw;
            out_stall <= (draw != 0);
        end
    end

    // Bound the run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_start_code_writes();
        test_hunting_and_good_frames();
        test_bad_frames();
        test_mid_frame_write();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
